@@ rtl/erpm_pkg.sv @@
// ----------------------------------------------------------------------------
// erpm_pkg
// Shared types and constants for the event rate peak meter.
// ----------------------------------------------------------------------------
package erpm_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [2:0] {
        KIND_EVENT      = 3'd0,
        KIND_SLICE_TICK = 3'd1,
        KIND_SECOND     = 3'd2,
        KIND_RST_CUR    = 3'd3,
        KIND_RST_SES    = 3'd4,
        KIND_RST_LIFE   = 3'd5
    } kind_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_LEAK_RATE    = 1'b0,
        REG_BUCKET_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_WIN_WAIT,
        ST_MWRITE,
        ST_SCAN,
        ST_SCAN_WAIT
    } state_t;

    localparam int          CNT_W          = 16;
    localparam int          TOT_W          = 32;
    localparam int          SLOT_W         = 6;
    localparam int          KIND_W         = 3;
    localparam int          S_TDATA_W      = 8;
    localparam int          M_TDATA_W      = 208;
    localparam logic [15:0] BUCKET_LIM_RST = 16'd5120;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;
    localparam logic [31:0] TOT_MAX        = 32'hFFFF_FFFF;

endpackage

@@ rtl/event_rate_peak_meter.sv @@
// ----------------------------------------------------------------------------
// event_rate_peak_meter
// Event counter with a ring of sub-second slices, sliding one-second peak
// search, per-second minute store, saturating totals and a leaky bucket.
// ----------------------------------------------------------------------------
//  channel  ports                      payload
//  input    s_tvalid/s_tready          s_tuser: kind; s_tdata: second_index
//  result   m_tvalid/m_tready          m_tdata: all counters and peaks
//  config   cfg_we/cfg_addr/cfg_wdata  0 leak_rate, 1 bucket_limit
//
//  events, slice ticks, resets and unused kinds are handled in the idle state; a new
//  request is taken every cycle while the result register drains
//  a second tick searches the span, stores the peak in its minute slot and scans
//  the store: one ring read per slice of the span, then one minute store read per slot
//  aresetn clears all counters, peaks and both stores (through valid bits) and resets
//  the configuration to leak_rate 0, bucket_limit 5120; no clearing pass is needed
//  input stalls while a second tick runs or the result register is held
// ----------------------------------------------------------------------------
module event_rate_peak_meter #(
    parameter int SLICES_PER_SECOND = 8,
    parameter int RING_SLICES       = 16,
    parameter int MINUTE_SLOTS      = 60
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [5:0] second_index, [7:6] zero
    input  logic [erpm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] kind
    input  logic [erpm_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] slice_count, [47:16] current_total, [63:48] current_peak,
    // [79:64] minute_peak, [111:80] session_total, [127:112] session_peak,
    // [159:128] lifetime_total, [175:160] lifetime_peak,
    // [191:176] window_peak, [207:192] bucket_level
    output logic [erpm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_addr,
    input  logic [15:0]                      cfg_wdata
);

    localparam int SP   = (2 * SLICES_PER_SECOND - 1 > RING_SLICES) ?
                          RING_SLICES : 2 * SLICES_PER_SECOND - 1;
    localparam int W    = (SLICES_PER_SECOND > SP) ? SP : SLICES_PER_SECOND;
    localparam int RW   = $clog2(RING_SLICES);
    localparam int RAW  = RW + 1;
    localparam int JW   = $clog2(SP + 1);
    localparam int MW   = (MINUTE_SLOTS > 1) ? $clog2(MINUTE_SLOTS) : 1;
    localparam int SUMW = 17 + $clog2(W);
    localparam int SLOT_W_L = erpm_pkg::SLOT_W;

    // ---------------- registers ----------------
    erpm_pkg::state_t  state_reg, state_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       leak_reg, leak_next;
    logic [15:0]       limit_reg, limit_next;
    logic [15:0]       open_reg, open_next;
    logic [RW-1:0]     ptr_reg, ptr_next;
    logic [31:0]       tot_cur_reg, tot_cur_next;
    logic [31:0]       tot_ses_reg, tot_ses_next;
    logic [31:0]       tot_life_reg, tot_life_next;
    logic [15:0]       pk_cur_reg, pk_cur_next;
    logic [15:0]       pk_ses_reg, pk_ses_next;
    logic [15:0]       pk_life_reg, pk_life_next;
    logic [15:0]       pk_min_reg, pk_min_next;
    logic [15:0]       win_pk_reg, win_pk_next;
    logic [15:0]       bucket_reg, bucket_next;
    logic [RING_SLICES-1:0]  ring_vld_reg, ring_vld_next;
    logic [MINUTE_SLOTS-1:0] min_vld_reg, min_vld_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_old_reg, rd_old_next;
    logic              rd_eval_reg, rd_eval_next;
    logic              mrd_vld_reg, mrd_vld_next;
    // payload, no reset
    logic [SLOT_W_L-1:0] slot_reg, slot_next;
    logic [JW-1:0]     j_reg, j_next;
    logic [RW-1:0]     a_new_reg, a_new_next;
    logic [RW-1:0]     a_old_reg, a_old_next;
    logic [SUMW-1:0]   sum_reg, sum_next;
    logic [SUMW-1:0]   best_reg, best_next;
    logic [MW-1:0]     k_reg, k_next;

    // ---------------- memories ----------------
    logic [15:0] ring_mem [RING_SLICES];
    logic [15:0] min_mem  [MINUTE_SLOTS];
    logic [15:0] ring_new_q, ring_old_q, min_q;
    logic        ring_new_v, ring_old_v, min_v;
    logic        ring_we, min_we;
    logic [15:0] min_wdata;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ptr_reg] <= open_reg;
        end
        ring_new_q <= ring_mem[a_new_reg];
        ring_old_q <= ring_mem[a_old_reg];
        ring_new_v <= ring_vld_reg[a_new_reg];
        ring_old_v <= ring_vld_reg[a_old_reg];
    end

    always_ff @(posedge aclk) begin
        if (min_we) begin
            min_mem[slot_reg[MW-1:0]] <= min_wdata;
        end
        min_q <= min_mem[k_reg];
        min_v <= min_vld_reg[k_reg];
    end

    // ---------------- combinational helpers ----------------
    erpm_pkg::kind_t  kind;
    logic             in_acc;
    logic signed [25:0] lvl;
    logic [RAW-1:0]   start_raw, old_raw;
    logic [RW-1:0]    start_addr, old_addr;
    logic [SUMW-1:0]  acc;
    logic [15:0]      best_sat;
    logic [15:0]      min_val;

    assign kind = erpm_pkg::kind_t'(s_tuser);
    assign lvl  = $signed({10'd0, bucket_reg}) + $signed({2'd0, open_reg, 8'd0})
                - $signed({10'd0, leak_reg});

    // oldest slice of the span, and the slice one window before it
    always_comb begin
        start_raw  = {1'b0, ptr_reg} + RAW'(RING_SLICES - SP);
        start_addr = (start_raw >= RAW'(RING_SLICES)) ?
                     RW'(start_raw - RAW'(RING_SLICES)) : RW'(start_raw);
        old_raw    = {1'b0, start_addr} + RAW'(RING_SLICES - W);
        old_addr   = (old_raw >= RAW'(RING_SLICES)) ?
                     RW'(old_raw - RAW'(RING_SLICES)) : RW'(old_raw);
    end

    assign acc      = sum_reg + SUMW'(ring_new_v ? ring_new_q : 16'd0)
                    - SUMW'((rd_old_reg && ring_old_v) ? ring_old_q : 16'd0);
    assign best_sat = (best_reg > SUMW'(erpm_pkg::CNT_MAX)) ?
                      erpm_pkg::CNT_MAX : best_reg[15:0];
    assign min_val  = min_v ? min_q : 16'd0;

    assign s_tready = (state_reg == erpm_pkg::ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {bucket_reg, win_pk_reg, pk_life_reg, tot_life_reg, pk_ses_reg,
                       tot_ses_reg, pk_min_reg, pk_cur_reg, tot_cur_reg, open_reg};

    // ---------------- next state ----------------
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        leak_next     = leak_reg;
        limit_next    = limit_reg;
        open_next     = open_reg;
        ptr_next      = ptr_reg;
        tot_cur_next  = tot_cur_reg;
        tot_ses_next  = tot_ses_reg;
        tot_life_next = tot_life_reg;
        pk_cur_next   = pk_cur_reg;
        pk_ses_next   = pk_ses_reg;
        pk_life_next  = pk_life_reg;
        pk_min_next   = pk_min_reg;
        win_pk_next   = win_pk_reg;
        bucket_next   = bucket_reg;
        ring_vld_next = ring_vld_reg;
        min_vld_next  = min_vld_reg;
        rd_vld_next   = 1'b0;
        rd_old_next   = 1'b0;
        rd_eval_next  = 1'b0;
        mrd_vld_next  = 1'b0;
        slot_next     = slot_reg;
        j_next        = j_reg;
        a_new_next    = a_new_reg;
        a_old_next    = a_old_reg;
        sum_next      = sum_reg;
        best_next     = best_reg;
        k_next        = k_reg;
        ring_we       = 1'b0;
        min_we        = 1'b0;
        min_wdata     = best_sat;

        if (cfg_we) begin
            case (erpm_pkg::cfg_reg_t'(cfg_addr))
                erpm_pkg::REG_LEAK_RATE:    leak_next  = cfg_wdata;
                erpm_pkg::REG_BUCKET_LIMIT: limit_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            erpm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    m_tvalid_next = 1'b1;
                    case (kind)
                        erpm_pkg::KIND_EVENT: begin
                            if (open_reg != erpm_pkg::CNT_MAX) open_next = open_reg + 16'd1;
                            if (tot_cur_reg != erpm_pkg::TOT_MAX)
                                tot_cur_next = tot_cur_reg + 32'd1;
                            if (tot_ses_reg != erpm_pkg::TOT_MAX)
                                tot_ses_next = tot_ses_reg + 32'd1;
                            if (tot_life_reg != erpm_pkg::TOT_MAX)
                                tot_life_next = tot_life_reg + 32'd1;
                        end
                        erpm_pkg::KIND_SLICE_TICK: begin
                            if (leak_reg != 16'd0) begin
                                if (lvl[25]) begin
                                    bucket_next = 16'd0;
                                end else if (lvl[24:0] > {9'd0, limit_reg}) begin
                                    bucket_next = limit_reg;
                                end else begin
                                    bucket_next = lvl[15:0];
                                end
                            end
                            ring_we                = 1'b1;
                            ring_vld_next[ptr_reg] = 1'b1;
                            ptr_next  = (ptr_reg == RW'(RING_SLICES - 1)) ? '0 : ptr_reg + 1'b1;
                            open_next = 16'd0;
                        end
                        erpm_pkg::KIND_SECOND: begin
                            m_tvalid_next = 1'b0;
                            slot_next     = s_tdata[SLOT_W_L-1:0];
                            j_next        = '0;
                            a_new_next    = start_addr;
                            a_old_next    = old_addr;
                            sum_next      = '0;
                            best_next     = '0;
                            state_next    = erpm_pkg::ST_WIN;
                        end
                        erpm_pkg::KIND_RST_CUR: begin
                            open_next     = 16'd0;
                            tot_cur_next  = 32'd0;
                            pk_cur_next   = 16'd0;
                            pk_min_next   = 16'd0;
                            ring_vld_next = '0;
                            min_vld_next  = '0;
                            ptr_next      = '0;
                        end
                        erpm_pkg::KIND_RST_SES: begin
                            tot_ses_next = 32'd0;
                            pk_ses_next  = 16'd0;
                        end
                        erpm_pkg::KIND_RST_LIFE: begin
                            tot_life_next = 32'd0;
                        end
                        default: ;
                    endcase
                end
            end
            erpm_pkg::ST_WIN: begin
                rd_vld_next  = 1'b1;
                rd_old_next  = (j_reg >= JW'(W));
                rd_eval_next = (j_reg >= JW'(W - 1));
                a_new_next   = (a_new_reg == RW'(RING_SLICES - 1)) ? '0 : a_new_reg + 1'b1;
                a_old_next   = (a_old_reg == RW'(RING_SLICES - 1)) ? '0 : a_old_reg + 1'b1;
                j_next       = j_reg + 1'b1;
                if (j_reg == JW'(SP - 1)) state_next = erpm_pkg::ST_WIN_WAIT;
            end
            erpm_pkg::ST_WIN_WAIT: begin
                state_next = erpm_pkg::ST_MWRITE;
            end
            erpm_pkg::ST_MWRITE: begin
                if ({1'b0, slot_reg} < 7'(MINUTE_SLOTS)) begin
                    min_we                           = 1'b1;
                    min_vld_next[slot_reg[MW-1:0]] = 1'b1;
                end
                win_pk_next = best_sat;
                if (pk_cur_reg < best_sat)  pk_cur_next  = best_sat;
                if (pk_ses_reg < best_sat)  pk_ses_next  = best_sat;
                if (pk_life_reg < best_sat) pk_life_next = best_sat;
                pk_min_next = 16'd0;
                k_next      = '0;
                state_next  = erpm_pkg::ST_SCAN;
            end
            erpm_pkg::ST_SCAN: begin
                mrd_vld_next = 1'b1;
                k_next       = k_reg + 1'b1;
                if (k_reg == MW'(MINUTE_SLOTS - 1)) state_next = erpm_pkg::ST_SCAN_WAIT;
            end
            erpm_pkg::ST_SCAN_WAIT: begin
                m_tvalid_next = 1'b1;
                state_next    = erpm_pkg::ST_IDLE;
            end
            default: begin
                state_next = erpm_pkg::ST_IDLE;
            end
        endcase

        // sliding window sum, one slice in per cycle and one out once the window is full
        if (rd_vld_reg) begin
            sum_next = acc;
            if (rd_eval_reg && acc > best_reg) best_next = acc;
        end
        // minute-wide maximum over the store
        if (mrd_vld_reg && min_val > pk_min_reg) pk_min_next = min_val;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= erpm_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            leak_reg     <= 16'd0;
            limit_reg    <= erpm_pkg::BUCKET_LIM_RST;
            open_reg     <= 16'd0;
            ptr_reg      <= '0;
            tot_cur_reg  <= 32'd0;
            tot_ses_reg  <= 32'd0;
            tot_life_reg <= 32'd0;
            pk_cur_reg   <= 16'd0;
            pk_ses_reg   <= 16'd0;
            pk_life_reg  <= 16'd0;
            pk_min_reg   <= 16'd0;
            win_pk_reg   <= 16'd0;
            bucket_reg   <= 16'd0;
            ring_vld_reg <= '0;
            min_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            rd_old_reg   <= 1'b0;
            rd_eval_reg  <= 1'b0;
            mrd_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            leak_reg     <= leak_next;
            limit_reg    <= limit_next;
            open_reg     <= open_next;
            ptr_reg      <= ptr_next;
            tot_cur_reg  <= tot_cur_next;
            tot_ses_reg  <= tot_ses_next;
            tot_life_reg <= tot_life_next;
            pk_cur_reg   <= pk_cur_next;
            pk_ses_reg   <= pk_ses_next;
            pk_life_reg  <= pk_life_next;
            pk_min_reg   <= pk_min_next;
            win_pk_reg   <= win_pk_next;
            bucket_reg   <= bucket_next;
            ring_vld_reg <= ring_vld_next;
            min_vld_reg  <= min_vld_next;
            rd_vld_reg   <= rd_vld_next;
            rd_old_reg   <= rd_old_next;
            rd_eval_reg  <= rd_eval_next;
            mrd_vld_reg  <= mrd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        j_reg     <= j_next;
        a_new_reg <= a_new_next;
        a_old_reg <= a_old_next;
        sum_reg   <= sum_next;
        best_reg  <= best_next;
        k_reg     <= k_next;
    end

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != erpm_pkg::ST_IDLE |-> !s_tready)
        else $error("input taken while a second tick runs");

    a_second_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && kind == erpm_pkg::KIND_SECOND |=> state_reg == erpm_pkg::ST_WIN && !m_tvalid)
        else $error("second tick did not start the window search");

    a_rd_after_win: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(state_reg == erpm_pkg::ST_WIN))
        else $error("ring read data without an issued read");

    a_scan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == erpm_pkg::ST_SCAN_WAIT |=> m_tvalid && state_reg == erpm_pkg::ST_IDLE)
        else $error("second tick result not presented after the scan");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= RW'(RING_SLICES - 1))
        else $error("ring pointer out of range");
`endif

endmodule
